// ----- rtl/cir_pkg.sv -----
// Shared types, codes and helpers for the contact impulse resolver.
`default_nettype none
package cir_pkg;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_CONTACT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [2:0] ATTR_POS_X = 3'd0;
  localparam logic [2:0] ATTR_POS_Y = 3'd1;
  localparam logic [2:0] ATTR_VEL_X = 3'd2;
  localparam logic [2:0] ATTR_VEL_Y = 3'd3;
  localparam logic [2:0] ATTR_IMASS = 3'd4;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 32;
  localparam int QUO_W  = 34;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         first_index;
    logic [5:0]         second_index;
    logic               second_present;
    logic [2:0]         attribute;
    logic signed [31:0] value;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [15:0]        restitution;
    logic signed [31:0] penetration;
  } in_t;

  typedef struct packed {
    logic [5:0]         body_index;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic [30:0]        inverse_mass;
    logic               impulse_applied;
    logic               bodies_moved;
  } out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        inv_mass;
  } body_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    if ((&x[PROD_W-1:31]) || !(|x[PROD_W-1:31])) begin
      return x[31:0];
    end
    return x[PROD_W-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/cir_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module cir_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [cir_pkg::DVD_W-1:0] dividend,
  input  wire logic [cir_pkg::DVS_W-1:0] divisor,
  output logic                           done,
  output logic      [cir_pkg::QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(cir_pkg::QUO_W + 1);

  logic [cir_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [cir_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [cir_pkg::DVS_W:0]   trial;
  logic                      ge;

  // quotient is known to fit QUO_W bits, so the upper dividend bits seed the remainder
  always_comb begin
    trial    = {rem_r, quo_r[cir_pkg::QUO_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = cir_pkg::DVS_W'(dividend[cir_pkg::DVD_W-1:cir_pkg::QUO_W]);
      quo_nxt  = dividend[cir_pkg::QUO_W-1:0];
      cnt_nxt  = CNT_W'(cir_pkg::QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? cir_pkg::DVS_W'(trial - {1'b0, divisor}) : trial[cir_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[cir_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- rtl/contact_impulse_resolver_unit.sv -----
// Top level: body table, sequencer, shared multiplier and contact resolution.
//
// Holds BODY_COUNT bodies in one RAM row each. After reset the block
// zeroes the table and takes no beat meanwhile. It then works on one beat
// at a time: a write reads, modifies and writes back one body row, a read
// reads it, and an unknown or out-of-range item goes straight to the output.
// A contact updates the velocity or position of each body in turn (up to
// four updates) through the 34-step serial divider and the single 34x34
// multiplier that every product goes through. A finished result waits
// in the output register while the next beat is already taken.
`default_nettype none
module contact_impulse_resolver_unit #(
  parameter int BODY_COUNT = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire cir_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output cir_pkg::out_t       out_data
);

  localparam int AW = $clog2(BODY_COUNT);
  localparam int BW = $bits(cir_pkg::body_t);

  typedef enum logic [20:0] {
    S_CLEAR    = 21'h000001,
    S_IDLE     = 21'h000002,
    S_RD_A     = 21'h000004,
    S_RD_B     = 21'h000008,
    S_LOAD     = 21'h000010,
    S_WMOD     = 21'h000020,
    S_MUL_RX   = 21'h000040,
    S_MUL_RY   = 21'h000080,
    S_SEP      = 21'h000100,
    S_MUL_D    = 21'h000200,
    S_D_CAP    = 21'h000400,
    S_PICK     = 21'h000800,
    S_MUL_Q    = 21'h001000,
    S_DIV_GO   = 21'h002000,
    S_DIV_WAIT = 21'h004000,
    S_MUL_NX   = 21'h008000,
    S_MUL_NY   = 21'h010000,
    S_UPD      = 21'h020000,
    S_WR_A     = 21'h040000,
    S_WR_B     = 21'h080000,
    S_OUT      = 21'h100000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [AW-1:0]                     clr_r, clr_nxt;
  logic                              out_valid_r, out_valid_nxt;
  cir_pkg::out_t                     out_r, out_nxt;
  cir_pkg::in_t                      item_r, item_nxt;
  cir_pkg::body_t                    a_r, a_nxt, b_r, b_nxt;
  logic signed [cir_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [cir_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic signed [cir_pkg::PROD_W-1:0] tx_r, tx_nxt;
  logic signed [31:0]                s_r, s_nxt;
  logic [cir_pkg::MUL_W-1:0]         d_r, d_nxt;
  logic                              imp_r, imp_nxt;
  logic                              mov_r, mov_nxt;
  logic [1:0]                        ph_r, ph_nxt;

  logic signed [cir_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  cir_pkg::body_t                    ram_wdata, ram_rdata;
  logic                              div_start, div_done;
  logic [cir_pkg::QUO_W-1:0]         div_q;

  logic [AW-1:0]                     addr_a, addr_b;
  logic                              in_rng_a, in_rng_b, it_rng_a;
  logic                              two, same, act;
  logic signed [32:0]                rx, ry;
  logic [31:0]                       total;
  logic signed [cir_pkg::PROD_W-1:0] sep_sum, t_x, t_y;
  logic signed [31:0]                sep_s, cx, cy, nx_new, ny_new;

  cir_ram #(
    .WIDTH (BW),
    .DEPTH (BODY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[cir_pkg::DVD_W-1:0]),
    .divisor  (total),
    .done     (div_done),
    .quotient (div_q)
  );

  assign addr_a   = AW'(item_r.first_index);
  assign addr_b   = AW'(item_r.second_index);
  assign in_rng_a = {26'd0, in_data.first_index} < 32'(BODY_COUNT);
  assign in_rng_b = {26'd0, in_data.second_index} < 32'(BODY_COUNT);
  assign it_rng_a = {26'd0, item_r.first_index} < 32'(BODY_COUNT);
  assign two      = item_r.second_present;
  assign same     = two && (item_r.second_index == item_r.first_index);
  assign rx       = $signed({a_r.vel_x[31], a_r.vel_x}) - $signed({b_r.vel_x[31], b_r.vel_x});
  assign ry       = $signed({a_r.vel_y[31], a_r.vel_y}) - $signed({b_r.vel_y[31], b_r.vel_y});
  assign total    = {1'b0, a_r.inv_mass} + {1'b0, b_r.inv_mass};
  assign sep_sum  = acc_r + prod_r;
  assign sep_s    = cir_pkg::sat32(sep_sum >>> 14);
  assign act      = (ph_r[1] ? mov_r : imp_r) && (!ph_r[0] || two);
  assign t_x      = ph_r[0] ? -tx_r : tx_r;
  assign t_y      = ph_r[0] ? -(prod_r >>> 14) : (prod_r >>> 14);

  always_comb begin
    unique case (ph_r)
      2'd0: begin
        cx = a_r.vel_x;
        cy = a_r.vel_y;
      end
      2'd1: begin
        cx = b_r.vel_x;
        cy = b_r.vel_y;
      end
      2'd2: begin
        cx = a_r.pos_x;
        cy = a_r.pos_y;
      end
      default: begin
        cx = b_r.pos_x;
        cy = b_r.pos_y;
      end
    endcase
    nx_new = cir_pkg::sat32(cir_pkg::PROD_W'(cx) + t_x);
    ny_new = cir_pkg::sat32(cir_pkg::PROD_W'(cy) + t_y);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    item_nxt      = item_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    tx_nxt        = tx_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    imp_nxt       = imp_r;
    mov_nxt       = mov_r;
    ph_nxt        = ph_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    ram_waddr     = addr_a;
    ram_wdata     = a_r;
    ram_raddr     = addr_a;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(BODY_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          imp_nxt  = 1'b0;
          mov_nxt  = 1'b0;
          priority if ((in_data.operation == cir_pkg::OP_WRITE ||
                        in_data.operation == cir_pkg::OP_READ) && in_rng_a) begin
            state_nxt = S_RD_A;
          end else if (in_data.operation == cir_pkg::OP_CONTACT && in_rng_a &&
                       (!in_data.second_present || in_rng_b)) begin
            state_nxt = S_RD_A;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD_A: begin
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        a_nxt     = ram_rdata;
        ram_raddr = addr_b;
        priority if (item_r.operation == cir_pkg::OP_READ) begin
          state_nxt = S_OUT;
        end else if (item_r.operation == cir_pkg::OP_WRITE) begin
          state_nxt = S_WMOD;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        b_nxt     = two ? ram_rdata : '0;
        state_nxt = S_MUL_RX;
      end
      S_WMOD: begin
        unique case (item_r.attribute)
          cir_pkg::ATTR_POS_X: a_nxt.pos_x = item_r.value;
          cir_pkg::ATTR_POS_Y: a_nxt.pos_y = item_r.value;
          cir_pkg::ATTR_VEL_X: a_nxt.vel_x = item_r.value;
          cir_pkg::ATTR_VEL_Y: a_nxt.vel_y = item_r.value;
          cir_pkg::ATTR_IMASS: a_nxt.inv_mass = item_r.value[31] ? '0 : item_r.value[30:0];
          default: a_nxt = a_r;
        endcase
        state_nxt = S_WR_A;
      end
      S_MUL_RX: begin
        mul_a     = cir_pkg::MUL_W'(rx);
        mul_b     = cir_pkg::MUL_W'(item_r.normal_x);
        state_nxt = S_MUL_RY;
      end
      S_MUL_RY: begin
        acc_nxt   = prod_r;
        mul_a     = cir_pkg::MUL_W'(ry);
        mul_b     = cir_pkg::MUL_W'(item_r.normal_y);
        state_nxt = S_SEP;
      end
      S_SEP: begin
        s_nxt     = sep_s;
        imp_nxt   = sep_s[31] && (total != '0);
        mov_nxt   = !item_r.penetration[31] && (item_r.penetration != '0) && (total != '0);
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        mul_a     = -cir_pkg::MUL_W'(s_r);
        mul_b     = $signed(cir_pkg::MUL_W'(item_r.restitution) + cir_pkg::MUL_W'(32768));
        state_nxt = S_D_CAP;
      end
      S_D_CAP: begin
        d_nxt     = prod_r[cir_pkg::MUL_W+14:15];
        ph_nxt    = 2'd0;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (act) begin
          if (ph_r == 2'd3 && same) begin
            b_nxt.pos_x = a_r.pos_x;
            b_nxt.pos_y = a_r.pos_y;
          end
          state_nxt = S_MUL_Q;
        end else if (ph_r == 2'd3) begin
          state_nxt = S_WR_A;
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end
      S_MUL_Q: begin
        mul_a     = ph_r[1] ? cir_pkg::MUL_W'(item_r.penetration) : $signed(d_r);
        mul_b     = $signed(cir_pkg::MUL_W'(ph_r[0] ? b_r.inv_mass : a_r.inv_mass));
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_MUL_NX;
        end
      end
      S_MUL_NX: begin
        mul_a     = cir_pkg::MUL_W'(item_r.normal_x);
        mul_b     = $signed(div_q);
        state_nxt = S_MUL_NY;
      end
      S_MUL_NY: begin
        tx_nxt    = prod_r >>> 14;
        mul_a     = cir_pkg::MUL_W'(item_r.normal_y);
        mul_b     = $signed(div_q);
        state_nxt = S_UPD;
      end
      S_UPD: begin
        unique case (ph_r)
          2'd0: begin
            a_nxt.vel_x = nx_new;
            a_nxt.vel_y = ny_new;
          end
          2'd1: begin
            b_nxt.vel_x = nx_new;
            b_nxt.vel_y = ny_new;
          end
          2'd2: begin
            a_nxt.pos_x = nx_new;
            a_nxt.pos_y = ny_new;
          end
          default: begin
            b_nxt.pos_x = nx_new;
            b_nxt.pos_y = ny_new;
          end
        endcase
        if (ph_r == 2'd3) begin
          state_nxt = S_WR_A;
        end else begin
          ph_nxt    = ph_r + 1'b1;
          state_nxt = S_PICK;
        end
      end
      S_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a;
        ram_wdata = a_r;
        state_nxt = (item_r.operation == cir_pkg::OP_CONTACT && two) ? S_WR_B : S_OUT;
      end
      S_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = b_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt            = '0;
          out_nxt.body_index = item_r.first_index;
          if (item_r.operation == cir_pkg::OP_READ && it_rng_a) begin
            out_nxt.position_x   = a_r.pos_x;
            out_nxt.position_y   = a_r.pos_y;
            out_nxt.velocity_x   = a_r.vel_x;
            out_nxt.velocity_y   = a_r.vel_y;
            out_nxt.inverse_mass = a_r.inv_mass;
          end
          if (item_r.operation == cir_pkg::OP_CONTACT) begin
            out_nxt.impulse_applied = imp_r;
            out_nxt.bodies_moved    = mov_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      imp_r       <= 1'b0;
      mov_r       <= 1'b0;
      ph_r        <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      imp_r       <= imp_nxt;
      mov_r       <= mov_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    item_r <= item_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    tx_r   <= tx_nxt;
    s_r    <= s_nxt;
    d_r    <= d_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- tb/sv/contact_impulse_resolver_unit_tb.sv -----
// Testbench for the contact impulse resolver: random and directed beats against a body-table model.
`default_nettype none
module contact_impulse_resolver_unit_tb;

  localparam int BODIES = 64;
  localparam int RANDOM_BEATS = 1600;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [2:0] ATTR_INVALID = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cir_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cir_pkg::out_t out_data;

  contact_impulse_resolver_unit #(.BODY_COUNT(BODIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  logic signed [31:0] tab_px [BODIES];
  logic signed [31:0] tab_py [BODIES];
  logic signed [31:0] tab_vx [BODIES];
  logic signed [31:0] tab_vy [BODIES];
  logic [30:0] tab_im [BODIES];

  cir_pkg::in_t pending_beats[$];
  cir_pkg::out_t expected_bodies[$];
  int errors = 0;
  longint cycles = 0;
  bit stimulus_done = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic longint floor_div2(input longint x, input int n);
    return x >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Add sign * floor(n*q/2^14) to a pair of components.
  function automatic void push_pair(inout logic signed [31:0] cx,
                                    inout logic signed [31:0] cy,
                                    input longint nx, input longint ny, input longint q,
                                    input bit neg);
    longint tx, ty;
    tx = floor_div2(nx * q, 14);
    ty = floor_div2(ny * q, 14);
    if (neg) begin
      tx = -tx;
      ty = -ty;
    end
    cx = clamp32(longint'(cx) + tx);
    cy = clamp32(longint'(cy) + ty);
  endfunction

  function automatic cir_pkg::out_t resolve_beat(input cir_pkg::in_t b);
    cir_pkg::out_t r;
    int a, c;
    longint rx, ry, s, nx, ny, pen;
    longint unsigned im1, im2, total, d, p;
    r = '0;
    r.body_index = b.first_index;
    a = int'(b.first_index);
    c = int'(b.second_index);
    nx = longint'(b.normal_x);
    ny = longint'(b.normal_y);
    pen = longint'(b.penetration);
    case (b.operation)
      cir_pkg::OP_WRITE: begin
        case (b.attribute)
          cir_pkg::ATTR_POS_X: tab_px[a] = b.value;
          cir_pkg::ATTR_POS_Y: tab_py[a] = b.value;
          cir_pkg::ATTR_VEL_X: tab_vx[a] = b.value;
          cir_pkg::ATTR_VEL_Y: tab_vy[a] = b.value;
          cir_pkg::ATTR_IMASS: tab_im[a] = b.value < 0 ? 31'd0 : b.value[30:0];
          default: ;
        endcase
      end
      cir_pkg::OP_READ: begin
        r.position_x = tab_px[a];
        r.position_y = tab_py[a];
        r.velocity_x = tab_vx[a];
        r.velocity_y = tab_vy[a];
        r.inverse_mass = tab_im[a];
      end
      cir_pkg::OP_CONTACT: begin
        im1 = 64'(tab_im[a]);
        im2 = 0;
        rx = longint'(tab_vx[a]);
        ry = longint'(tab_vy[a]);
        if (b.second_present) begin
          im2 = 64'(tab_im[c]);
          rx -= longint'(tab_vx[c]);
          ry -= longint'(tab_vy[c]);
        end
        total = im1 + im2;
        s = longint'(clamp32(floor_div2(rx * nx + ry * ny, 14)));
        if (s < 0 && total > 0) begin
          d = (64'(-s) * (64'd32768 + 64'(b.restitution))) >> 15;
          push_pair(tab_vx[a], tab_vy[a], nx, ny, longint'((d * im1) / total), 1'b0);
          if (b.second_present)
            push_pair(tab_vx[c], tab_vy[c], nx, ny, longint'((d * im2) / total), 1'b1);
          r.impulse_applied = 1'b1;
        end
        if (pen > 0 && total > 0) begin
          p = 64'(pen);
          push_pair(tab_px[a], tab_py[a], nx, ny, longint'((p * im1) / total), 1'b0);
          if (b.second_present)
            push_pair(tab_px[c], tab_py[c], nx, ny, longint'((p * im2) / total), 1'b1);
          r.bodies_moved = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  function automatic cir_pkg::in_t rand_beat();
    cir_pkg::in_t b;
    int roll;
    b = '0;
    b.value = $urandom;
    b.normal_x = 16'($urandom);
    b.normal_y = 16'($urandom);
    b.restitution = 16'($urandom);
    b.penetration = $urandom;
    b.first_index = 6'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) b.first_index = 6'($urandom);
    b.second_index = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 7));
    b.second_present = 1'($urandom);
    b.attribute = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(0, 4));
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      b.operation = cir_pkg::OP_WRITE;
      if (b.attribute == cir_pkg::ATTR_IMASS)
        b.value = $urandom_range(0, 9) == 0 ? 32'($urandom) : 32'($urandom_range(0, 32'h30000));
      else
        b.value = rand_q16();
    end else if (roll < 75) begin
      b.operation = cir_pkg::OP_CONTACT;
      if ($urandom_range(0, 3) != 0) begin
        b.normal_x = 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
        b.normal_y = 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
        b.restitution = 16'($urandom_range(0, 32768));
        b.penetration = $signed($urandom_range(0, 32'h40000)) - 32'sh10000;
      end
    end else if (roll < 97) begin
      b.operation = cir_pkg::OP_READ;
    end else begin
      b.operation = OP_UNKNOWN;
    end
    return b;
  endfunction

  function automatic cir_pkg::in_t make_beat(input logic [1:0] op, input logic [5:0] a,
                                             input logic [2:0] attr,
                                             input logic signed [31:0] v);
    cir_pkg::in_t b;
    b = '0;
    b.operation = op;
    b.first_index = a;
    b.attribute = attr;
    b.value = v;
    return b;
  endfunction

  initial begin
    cir_pkg::in_t b;
    for (int i = 0; i < BODIES; i++) begin
      tab_px[i] = '0; tab_py[i] = '0; tab_vx[i] = '0; tab_vy[i] = '0; tab_im[i] = '0;
    end
    pending_beats.push_back(make_beat(cir_pkg::OP_READ, 6'd63, cir_pkg::ATTR_POS_X, 32'sd0));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd1, cir_pkg::ATTR_IMASS, 32'sh00010000));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd2, cir_pkg::ATTR_IMASS, 32'sh00020000));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd3, cir_pkg::ATTR_IMASS, 32'sh80000000));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd1, cir_pkg::ATTR_VEL_X, 32'sh7fffffff));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd2, cir_pkg::ATTR_VEL_X, 32'sh80000000));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd1, cir_pkg::ATTR_POS_Y, 32'sh7fffffff));
    pending_beats.push_back(make_beat(cir_pkg::OP_WRITE, 6'd2, ATTR_INVALID, 32'sh12345678));
    // head-on contact, full restitution, penetration
    b = make_beat(cir_pkg::OP_CONTACT, 6'd1, cir_pkg::ATTR_POS_X, 32'sd0);
    b.second_index = 6'd2; b.second_present = 1'b1;
    b.normal_x = -16'sd16384; b.restitution = 16'd32768; b.penetration = 32'sh00010000;
    pending_beats.push_back(b);
    // same body twice
    b.second_index = 6'd1; b.restitution = 16'hffff; b.normal_y = 16'sh7fff;
    pending_beats.push_back(b);
    // world contact with max-ish fields
    b = make_beat(cir_pkg::OP_CONTACT, 6'd2, cir_pkg::ATTR_POS_X, 32'sd0);
    b.second_index = 6'd63; b.normal_x = 16'sh8000; b.normal_y = 16'sh8000;
    b.penetration = 32'sh7fffffff;
    pending_beats.push_back(b);
    // zero total inverse mass
    b.first_index = 6'd3; b.second_present = 1'b1; b.second_index = 6'd4;
    pending_beats.push_back(b);
    pending_beats.push_back(make_beat(OP_UNKNOWN, 6'd5, cir_pkg::ATTR_POS_X, 32'sd0));
    for (int i = 1; i <= 4; i++)
      pending_beats.push_back(make_beat(cir_pkg::OP_READ, 6'(i), cir_pkg::ATTR_POS_X, 32'sd0));
    for (int i = 0; i < RANDOM_BEATS; i++) pending_beats.push_back(rand_beat());
    stimulus_done = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles < 7) begin
      rst_n <= 1'b0;
    end else begin
      rst_n <= 1'b1;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("contact_impulse_resolver_unit_tb: done, errors");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_bodies.push_back(resolve_beat(in_data));
        void'(pending_beats.pop_front());
        in_gap = pick_gap();
        if (in_gap == 0 && pending_beats.size() > 0) begin
          in_data <= pending_beats[0];
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_beats[0];
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cir_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bodies.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          want = expected_bodies.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        out_gap = pick_gap();
        out_stall <= out_gap > 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (rst_n);
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_bodies.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_bodies.size() == 0) begin
      $display("contact_impulse_resolver_unit_tb: done, clean");
    end else begin
      $display("contact_impulse_resolver_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/cir_pkg.sv
rtl/cir_ram.sv
rtl/cir_div.sv
rtl/contact_impulse_resolver_unit.sv
tb/sv/contact_impulse_resolver_unit_tb.sv
